/* sv/digit_to_dot_matrix_leds_assert.svh */
// Assertion macros shared by the dot-matrix digit block.
`ifndef DIGIT_TO_DOT_MATRIX_LEDS_ASSERT_SVH
`define DIGIT_TO_DOT_MATRIX_LEDS_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define DTDM_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define DTDM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dtdm_pkg.sv */
`default_nettype none

package dtdm_pkg;

    // Dot matrix geometry
    localparam int NUM_COLS      = 5;
    localparam int NUM_ROWS      = 7;
    localparam int NUM_POSITIONS = NUM_COLS * NUM_ROWS;
    localparam int NUM_DIGITS    = 10;

    // Segment bits a..g
    localparam logic [6:0] SEG_A = 7'h01;
    localparam logic [6:0] SEG_B = 7'h02;
    localparam logic [6:0] SEG_C = 7'h04;
    localparam logic [6:0] SEG_D = 7'h08;
    localparam logic [6:0] SEG_E = 7'h10;
    localparam logic [6:0] SEG_F = 7'h20;
    localparam logic [6:0] SEG_G = 7'h40;

    typedef logic [NUM_POSITIONS-1:0] dot_mask_t;

    // Seven-segment patterns for digits 0..9
    localparam logic [6:0] SEG_TABLE [NUM_DIGITS] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Dot positions of each segment, bit = row*5 + col
    localparam dot_mask_t MASK_A = 35'h1F;
    localparam dot_mask_t MASK_B = 35'h0_0008_4210;
    localparam dot_mask_t MASK_C = 35'h4_2108_0000;
    localparam dot_mask_t MASK_D = 35'h1F << 30;
    localparam dot_mask_t MASK_E = 35'h0_4210_8000;
    localparam dot_mask_t MASK_F = 35'h0_0000_8421;
    localparam dot_mask_t MASK_G = 35'h1F << 15;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take a new digit transaction
        logic step;   // examine the current dot position
    } dtdm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_full;   // output register holds a dot not yet taken
        logic scan_end;   // no lit dots past the current position
    } dtdm_status_t;

    // Digit code to lit dot mask; blank codes give no dots
    function automatic dot_mask_t digit_mask(input logic [3:0] code);
        logic [6:0] s;
        dot_mask_t  m;
        s = 7'h00;
        m = '0;
        if (code <= 4'(NUM_DIGITS - 1))
            s = SEG_TABLE[code];
        if ((s & SEG_A) != 7'h00) m = m | MASK_A;
        if ((s & SEG_B) != 7'h00) m = m | MASK_B;
        if ((s & SEG_C) != 7'h00) m = m | MASK_C;
        if ((s & SEG_D) != 7'h00) m = m | MASK_D;
        if ((s & SEG_E) != 7'h00) m = m | MASK_E;
        if ((s & SEG_F) != 7'h00) m = m | MASK_F;
        if ((s & SEG_G) != 7'h00) m = m | MASK_G;
        return m;
    endfunction

    // 8-bit value mod 3 via base-4 digit sums (4 == 1 mod 3)
    function automatic logic [1:0] mod3_u8(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        logic [2:0] r;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd6)
            r = t - 3'd6;
        else if (t >= 3'd3)
            r = t - 3'd3;
        else
            r = t;
        return r[1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/digit_to_dot_matrix_leds.sv */
// Digit to 5x7 dot-matrix LED list.
// Slave stream s_*: one transaction per digit (code, leftmost column).
// Master stream m_*: one transaction per lit dot in row-major order, with
// tlast on the final dot of the digit. Blank codes (10..15) give none.
// Config channel cfg_*: row origin of the top dot row, always ready. The user
// must see that it is written only while the block is idle; the block does
// not enforce this. Reset value is 96. Throughput: one digit at a time.
// The scan walks the 35 positions one per cycle while the output is not
// stalled and ends right after the last lit dot; a blank digit ends at the
// first position. With the output register free, m_tvalid rises after the
// scan step on the first lit dot, which for a 1 is in column 4.
// A stalled receiver holds the output register and freezes the scan;
// s_tready stays low until the scan of the current digit is done.
// Reset clears the scan and the output valid; no clearing pass is needed.
`default_nettype none

module digit_to_dot_matrix_leds #(
    parameter int PITCH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [3:0] digit_code, [11:4] column_origin
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // [7:0] dot_x, [15:8] dot_y, [17:16] shade
    output logic             m_tlast,    // last_dot
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data    // row_origin
);

    dtdm_pkg::dtdm_cmd_t    cmd;
    dtdm_pkg::dtdm_status_t status;
    logic [7:0]             dot_x;
    logic [7:0]             dot_y;
    logic [1:0]             shade;

    assign cfg_ready = 1'b1;

    dtdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dtdm_datapath #(
        .PITCH (PITCH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .digit_code    (s_tdata[3:0]),
        .column_origin (s_tdata[11:4]),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .dot_x         (dot_x),
        .dot_y         (dot_y),
        .shade         (shade),
        .last_dot      (m_tlast)
    );

    // Pack output fields
    assign m_tdata = {6'd0, shade, dot_y, dot_x};

    // Checks
`include "digit_to_dot_matrix_leds_assert.svh"

    `DTDM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "accepted a digit but still ready")
    `DTDM_ASSERT_NOW(a_no_step_when_idle, clk, rst_n, s_tready, !cmd.step, "scan step while idle")
    `DTDM_ASSERT_NOW(a_shade_range, clk, rst_n, m_tvalid, m_tdata[17:16] != 2'b11, "shade out of range")

endmodule

`default_nettype wire

/* sv/dtdm_ctrl.sv */
`default_nettype none

module dtdm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  out_ready,
    input  wire dtdm_pkg::dtdm_status_t status,
    output dtdm_pkg::dtdm_cmd_t        cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    // Scan may advance when the output slot is free or being emptied
    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.load = in_ready && in_valid;
    assign cmd.step = (state_reg == ST_SCAN) && (!status.out_full || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cmd.step && status.scan_end)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* sv/dtdm_datapath.sv */
`default_nettype none

module dtdm_datapath #(
    parameter int PITCH = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [3:0]          digit_code,
    input  wire logic [7:0]          column_origin,
    input  wire logic                cfg_valid,
    input  wire logic [7:0]          cfg_data,
    input  wire dtdm_pkg::dtdm_cmd_t cmd,
    output dtdm_pkg::dtdm_status_t   status,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [7:0]               dot_x,
    output logic [7:0]               dot_y,
    output logic [1:0]               shade,
    output logic                     last_dot
);

    localparam logic [7:0] PITCH_W  = 8'(PITCH);
    localparam logic [2:0] LAST_COL = 3'(dtdm_pkg::NUM_COLS - 1);

    logic [7:0]           row_origin_reg;
    dtdm_pkg::dot_mask_t  mask_reg;
    logic [7:0]           origin_reg;
    logic [7:0]           x_reg;
    logic [7:0]           y_reg;
    logic [2:0]           col_reg;
    logic [1:0]           shade_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_x_reg;
    logic [7:0]           out_y_reg;
    logic [1:0]           out_shade_reg;
    logic                 out_last_reg;
    logic                 lit;
    logic                 rest_empty;

    // Current position is mask bit 0; the mask shifts down as the scan moves
    assign lit        = mask_reg[0];
    assign rest_empty = (mask_reg[dtdm_pkg::NUM_POSITIONS-1:1] == '0);

    assign status.out_full = out_valid_reg;
    assign status.scan_end = rest_empty;

    // Row origin register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_origin_reg <= 8'd96;
        else if (cfg_valid)
            row_origin_reg <= cfg_data;
    end

    // Scan state: mask, column counter and running coordinates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            col_reg  <= '0;
        end
        else if (cmd.load)
        begin
            mask_reg <= dtdm_pkg::digit_mask(digit_code);
            col_reg  <= '0;
        end
        else if (cmd.step)
        begin
            mask_reg <= mask_reg >> 1;
            col_reg  <= (col_reg == LAST_COL) ? 3'd0 : col_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            origin_reg <= column_origin;
            x_reg      <= column_origin;
            y_reg      <= row_origin_reg;
            shade_reg  <= dtdm_pkg::mod3_u8(column_origin);
        end
        else if (cmd.step)
        begin
            if (col_reg == LAST_COL)
            begin
                // Row wrap: col drops by 4 and row rises by 1, shade unchanged mod 3
                x_reg <= origin_reg;
                y_reg <= y_reg + PITCH_W;
            end
            else
            begin
                x_reg     <= x_reg + PITCH_W;
                shade_reg <= (shade_reg == 2'd2) ? 2'd0 : shade_reg + 2'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.step && lit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && lit)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_shade_reg <= shade_reg;
            out_last_reg  <= rest_empty;
        end
    end

    assign out_valid = out_valid_reg;
    assign dot_x     = out_x_reg;
    assign dot_y     = out_y_reg;
    assign shade     = out_shade_reg;
    assign last_dot  = out_last_reg;

endmodule

`default_nettype wire
